// File: hdl/ntc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared types and codes of the NTC table interpolator.
// ----------------------------------------------------------------------------
package ntc_pkg;

   localparam int DIV_W = 32;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic CSR_TEMP_STEP     = 1'b0;
   localparam logic CSR_POINTS_IN_USE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_SLOPE = 2'd2;

   localparam logic [15:0] TEMP_STEP_RESET = 16'd5;
   localparam logic [6:0]  POINTS_RESET    = 7'd43;
   localparam logic [15:0] TEMP_MAX        = 16'h7FFF;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: hdl/ntc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntc_div (
   input  logic                clock,
   input  logic                reset,
   input  ntc_pkg::div_req_type req,
   output ntc_pkg::div_rsp_type rsp
);

   localparam int W     = ntc_pkg::DIV_W;
   localparam int CNT_W = $clog2(W + 1);

   logic [W:0]       rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [W:0]       rem_shift;
   logic [W:0]       diff;

   always_comb begin
      rem_shift = {rem_ff[W-1:0], quo_ff[W-1]};
      diff      = rem_shift - {1'b0, dvs_ff};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (req.start) begin
         rem_in = '0;
         quo_in = req.dividend;
         dvs_in = req.divisor;
         cnt_in = CNT_W'(W);
      end else if (cnt_ff != '0) begin
         if (!diff[W]) begin
            rem_in = diff;
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// File: hdl/ntc_table_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_table_interpolator_top
// NTC resistance to temperature by table scan and linear interpolation.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  req     | req_valid/req_stall + fields   | in
//  rsp     | rsp_valid/rsp_stall + fields   | out
//  csr     | csr_write/csr_index/csr_wdata  | in
//
//  A lookup reads the first and last points; at the range check or a match on
//  the first point it raises rsp_valid without a scan, else it scans points,
//  one per cycle, then runs the bit-serial divider: no run with a zero
//  temp_step, one with a zero slope, two otherwise. req_stall stays high
//  until the result is loaded. Reset is synchronous and leaves the table
//  undefined. A result held by rsp_stall blocks the next lookup only at its end.
// ----------------------------------------------------------------------------
module ntc_table_interpolator_top #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [5:0]  req_entry_index,
   input  logic signed [15:0] req_entry_temperature,
   input  logic [31:0] req_entry_resistance,
   input  logic [31:0] req_measured_resistance,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_temperature,
   output logic [1:0]  rsp_status,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FIRST = 3'd1;
   localparam logic [2:0] ST_LAST  = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DIV1  = 3'd4;
   localparam logic [2:0] ST_DIV2  = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [31:0] res_mem [TABLE_DEPTH];
   logic [15:0] tmp_mem [TABLE_DEPTH];

   logic [2:0]    state_ff, state_in;
   logic [15:0]   temp_step_ff;
   logic [6:0]    points_ff;
   logic [31:0]   meas_ff, meas_in;
   logic [AW-1:0] last_ff, last_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [31:0]   prev_r_ff, prev_r_in;
   logic [15:0]   prev_t_ff, prev_t_in;
   logic [31:0]   rd_r_ff;
   logic [15:0]   rd_t_ff;
   logic [15:0]   res_t_ff, res_t_in;
   logic [1:0]    res_s_ff, res_s_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_t_ff, rsp_t_in;
   logic [1:0]    rsp_s_ff, rsp_s_in;
   logic          start_ff, start_in;
   logic [31:0]   dvd_ff, dvd_in;
   logic [31:0]   dvs_ff, dvs_in;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] last_calc;
   logic          accept;
   logic          wr_en;
   logic          out_free;
   logic signed [33:0] sum;

   ntc_pkg::div_req_type div_req;
   ntc_pkg::div_rsp_type div_rsp;

   assign accept   = req_valid && !req_stall;
   assign wr_en    = accept && (req_opcode == ntc_pkg::OP_WRITE)
                     && (int'(req_entry_index) < TABLE_DEPTH);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      if (int'(points_ff) < 2) begin
         last_calc = AW'(1);
      end else if (int'(points_ff) > TABLE_DEPTH) begin
         last_calc = AW'(TABLE_DEPTH - 1);
      end else begin
         last_calc = AW'(points_ff - 7'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_step_ff <= ntc_pkg::TEMP_STEP_RESET;
         points_ff    <= ntc_pkg::POINTS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            ntc_pkg::CSR_TEMP_STEP:     temp_step_ff <= csr_wdata;
            ntc_pkg::CSR_POINTS_IN_USE: points_ff    <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         res_mem[AW'(req_entry_index)] <= req_entry_resistance;
         tmp_mem[AW'(req_entry_index)] <= req_entry_temperature;
      end
      rd_r_ff <= res_mem[rd_addr];
      rd_t_ff <= tmp_mem[rd_addr];
   end

   assign sum = $signed({{18{prev_t_ff[15]}}, prev_t_ff})
              + $signed({2'b00, div_rsp.quotient});

   always_comb begin
      state_in     = state_ff;
      meas_in      = meas_ff;
      last_in      = last_ff;
      cur_in       = cur_ff;
      prev_r_in    = prev_r_ff;
      prev_t_in    = prev_t_ff;
      res_t_in     = res_t_ff;
      res_s_in     = res_s_ff;
      start_in     = 1'b0;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      rd_addr      = cur_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_t_in     = rsp_t_ff;
      rsp_s_in     = rsp_s_ff;
      case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (accept && (req_opcode == ntc_pkg::OP_LOOKUP)) begin
               meas_in  = req_measured_resistance;
               last_in  = last_calc;
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            prev_r_in = rd_r_ff;
            prev_t_in = rd_t_ff;
            rd_addr   = last_ff;
            state_in  = ST_LAST;
         end
         ST_LAST: begin
            rd_addr = AW'(1);
            cur_in  = AW'(1);
            if (meas_ff > prev_r_ff || meas_ff < rd_r_ff) begin
               res_t_in = '0;
               res_s_in = ntc_pkg::STATUS_RANGE;
               state_in = ST_EMIT;
            end else if (meas_ff == prev_r_ff) begin
               res_t_in = prev_t_ff;
               res_s_in = ntc_pkg::STATUS_OK;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_r_ff <= meas_ff || cur_ff == last_ff) begin
               if (temp_step_ff == '0) begin
                  res_t_in = '0;
                  res_s_in = ntc_pkg::STATUS_SLOPE;
                  state_in = ST_EMIT;
               end else begin
                  start_in = 1'b1;
                  dvd_in   = prev_r_ff - rd_r_ff;
                  dvs_in   = {16'd0, temp_step_ff};
                  state_in = ST_DIV1;
               end
            end else begin
               prev_r_in = rd_r_ff;
               prev_t_in = rd_t_ff;
               cur_in    = cur_ff + 1'b1;
               rd_addr   = cur_ff + 1'b1;
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient == '0) begin
                  res_t_in = '0;
                  res_s_in = ntc_pkg::STATUS_SLOPE;
                  state_in = ST_EMIT;
               end else begin
                  start_in = 1'b1;
                  dvd_in   = prev_r_ff - meas_ff;
                  dvs_in   = div_rsp.quotient;
                  state_in = ST_DIV2;
               end
            end
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               res_t_in = (sum > 34'sd32767) ? ntc_pkg::TEMP_MAX : sum[15:0];
               res_s_in = ntc_pkg::STATUS_OK;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_t_in     = res_t_ff;
               rsp_s_in     = res_s_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         start_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
      end
      meas_ff   <= meas_in;
      last_ff   <= last_in;
      cur_ff    <= cur_in;
      prev_r_ff <= prev_r_in;
      prev_t_ff <= prev_t_in;
      res_t_ff  <= res_t_in;
      res_s_ff  <= res_s_in;
      dvd_ff    <= dvd_in;
      dvs_ff    <= dvs_in;
      rsp_t_ff  <= rsp_t_in;
      rsp_s_ff  <= rsp_s_in;
   end

   assign div_req.start    = start_ff;
   assign div_req.dividend = dvd_ff;
   assign div_req.divisor  = dvs_ff;

   ntc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = rsp_t_ff;
   assign rsp_status      = rsp_s_ff;

endmodule

// File: hdl/ntc_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_chk
// Port-level checks of the NTC table interpolator.
// ----------------------------------------------------------------------------
module ntc_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_opcode,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic signed [15:0] rsp_temperature,
   input logic [1:0]  rsp_status
);

   a_error_zero_temp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ntc_pkg::STATUS_OK) |-> (rsp_temperature == '0))
      else $error("nonzero temperature with error status");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode == ntc_pkg::OP_WRITE && !rsp_valid)
      |=> !rsp_valid)
      else $error("write transfer produced a result");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode == ntc_pkg::OP_LOOKUP) |=> req_stall)
      else $error("lookup did not hold off the next request");

endmodule

bind ntc_table_interpolator_top ntc_chk u_chk (.*);

// File: dv/ntc_table_interpolator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_table_interpolator_top_test
// Self-checking bench for the NTC table interpolator. Loads resistance and
// temperature tables, runs directed and random lookups over several register
// settings, and checks every reading against an in-bench interpolation model
// under random idle cycles, long stall stretches and back-pressure.
// ----------------------------------------------------------------------------
module ntc_table_interpolator_top_test;

   localparam int TABLE_DEPTH    = 64;
   localparam int IDLE_PERCENT   = 37;
   localparam int SETTLE_CYCLES  = 200;
   localparam int HOLD_CYCLES    = 500;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      logic               opcode;
      logic [5:0]         entry_index;
      logic signed [15:0] entry_temperature;
      logic [31:0]        entry_resistance;
      logic [31:0]        measured_resistance;
   } probe_item_type;

   typedef struct {
      logic signed [15:0] temperature;
      logic [1:0]         status;
   } reading_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_opcode = ntc_pkg::OP_WRITE;
   logic [5:0]         req_entry_index = '0;
   logic signed [15:0] req_entry_temperature = '0;
   logic [31:0]        req_entry_resistance = '0;
   logic [31:0]        req_measured_resistance = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_temperature;
   logic [1:0]         rsp_status;
   logic               csr_write = 1'b0;
   logic               csr_index = ntc_pkg::CSR_TEMP_STEP;
   logic [15:0]        csr_wdata = '0;

   logic [31:0]        point_ohms[TABLE_DEPTH];
   logic signed [15:0] point_temp[TABLE_DEPTH];
   logic [15:0]        step_reg = ntc_pkg::TEMP_STEP_RESET;
   logic [6:0]         points_reg = ntc_pkg::POINTS_RESET;

   reading_type        expected_readings[$];
   reading_type        oldest_reading;
   int                 error_count = 0;
   int                 quiet_cycles = 0;
   bit                 req_idle_en = 1'b1;
   bit                 rsp_idle_en = 1'b1;
   bit                 hold_toggle = 1'b0;
   bit                 hold_seen = 1'b0;
   int                 hold_left = 0;

   ntc_table_interpolator_top #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_opcode              (req_opcode),
      .req_entry_index         (req_entry_index),
      .req_entry_temperature   (req_entry_temperature),
      .req_entry_resistance    (req_entry_resistance),
      .req_measured_resistance (req_measured_resistance),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_temperature         (rsp_temperature),
      .rsp_status              (rsp_status),
      .csr_write               (csr_write),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned points_used();
      if (points_reg < 2) return 2;
      if (points_reg > TABLE_DEPTH) return TABLE_DEPTH;
      return 32'(points_reg);
   endfunction

   function automatic reading_type interpolate_temperature(input logic [31:0] meas);
      reading_type rd;
      int unsigned n;
      int unsigned i;
      logic [31:0] span;
      logic [31:0] slope;
      logic [31:0] offset;
      longint      t;
      n = points_used();
      rd.temperature = '0;
      rd.status = ntc_pkg::STATUS_OK;
      if (meas > point_ohms[0] || meas < point_ohms[n-1]) begin
         rd.status = ntc_pkg::STATUS_RANGE;
         return rd;
      end
      i = 0;
      while (i < n - 1 && point_ohms[i] > meas) i++;
      if (i == 0) begin
         rd.temperature = point_temp[0];
         return rd;
      end
      span = point_ohms[i-1] - point_ohms[i];
      slope = (step_reg == 0) ? 32'd0 : span / step_reg;
      if (slope == 0) begin
         rd.status = ntc_pkg::STATUS_SLOPE;
         return rd;
      end
      offset = (point_ohms[i-1] - meas) / slope;
      t = longint'(point_temp[i-1]) + longint'(offset);
      if (t > 32767) t = 32767;
      rd.temperature = t[15:0];
      return rd;
   endfunction

   function automatic probe_item_type make_write(input logic [5:0] idx,
                                                 input logic signed [15:0] temp,
                                                 input logic [31:0] ohms);
      probe_item_type it;
      it.opcode = ntc_pkg::OP_WRITE;
      it.entry_index = idx;
      it.entry_temperature = temp;
      it.entry_resistance = ohms;
      it.measured_resistance = $urandom;
      return it;
   endfunction

   function automatic probe_item_type make_lookup(input logic [31:0] meas);
      probe_item_type it;
      it.opcode = ntc_pkg::OP_LOOKUP;
      it.entry_index = 6'($urandom);
      it.entry_temperature = 16'($urandom);
      it.entry_resistance = $urandom;
      it.measured_resistance = meas;
      return it;
   endfunction

   function automatic logic [31:0] pick_measurement();
      int unsigned n;
      int unsigned i;
      int unsigned sel;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] pick;
      n = points_used();
      sel = $urandom_range(99);
      i = $urandom_range(n - 1, 1);
      hi = 64'(point_ohms[i-1]);
      lo = 64'(point_ohms[i]);
      if (hi < lo) begin
         hi = 64'(point_ohms[i]);
         lo = 64'(point_ohms[i-1]);
      end
      if (sel < 10) return point_ohms[0];
      if (sel < 16) return point_ohms[0] + 32'd1;
      if (sel < 22) return point_ohms[n-1] - 32'd1;
      if (sel < 32) return $urandom;
      if (sel < 42) return point_ohms[i];
      pick = lo + ({32'd0, $urandom} % (hi - lo + 64'd1));
      return pick[31:0];
   endfunction

   function automatic probe_item_type random_item();
      if ($urandom_range(9) == 0)
         return make_write(6'($urandom), 16'($urandom), $urandom);
      return make_lookup(pick_measurement());
   endfunction

   task automatic send_item(input probe_item_type it);
      if (req_idle_en) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_opcode <= it.opcode;
      req_entry_index <= it.entry_index;
      req_entry_temperature <= it.entry_temperature;
      req_entry_resistance <= it.entry_resistance;
      req_measured_resistance <= it.measured_resistance;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (it.opcode == ntc_pkg::OP_WRITE) begin
         point_ohms[it.entry_index] = it.entry_resistance;
         point_temp[it.entry_index] = it.entry_temperature;
      end else begin
         expected_readings.push_back(interpolate_temperature(it.measured_resistance));
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [15:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == ntc_pkg::CSR_TEMP_STEP) step_reg = data;
      else points_reg = data[6:0];
   endtask

   task automatic load_table();
      logic [63:0]        ohms;
      logic [63:0]        drop;
      logic signed [15:0] temp;
      int unsigned        grain;
      int unsigned        k;
      grain = (step_reg == 0) ? 1 : 32'(step_reg);
      ohms = 64'hFFFF_FFFF - 64'($urandom_range(32'h3FFF_FFFF, 0));
      temp = 16'($urandom);
      for (k = 0; k < points_used(); k++) begin
         send_item(make_write(6'(k), temp, ohms[31:0]));
         if ($urandom_range(9) == 0)
            drop = 64'($urandom_range(grain, 0));
         else
            drop = 64'(grain) * 64'($urandom_range(400, 1))
                 + 64'($urandom_range(grain - 1, 0));
         ohms = (drop > ohms) ? 64'd0 : ohms - drop;
         temp = temp + signed'(step_reg);
      end
   endtask

   task automatic test_directed();
      logic [63:0]        ohms;
      logic signed [15:0] temp;
      int unsigned        k;
      ohms = 64'hFFFF_FFFF;
      temp = 16'sh8000;
      for (k = 0; k < TABLE_DEPTH; k++) begin
         if (k == 5) ohms = ohms - 3;
         else if (k == 10) ohms = ohms - 9;
         else if (k == TABLE_DEPTH - 1) ohms = 0;
         else if (k != 0) ohms = ohms - 1000;
         if (k == 9) temp = 16'sd32765;
         else if (k == TABLE_DEPTH - 1) temp = 16'sd32767;
         else if (k != 0) temp = temp + 16'sd5;
         send_item(make_write(6'(k), temp, ohms[31:0]));
      end
      send_item(make_lookup(32'hFFFF_FFFF));
      send_item(make_lookup(point_ohms[1]));
      send_item(make_lookup(point_ohms[1] + 32'd500));
      send_item(make_lookup(point_ohms[5] + 32'd1));
      send_item(make_lookup(point_ohms[9] - 32'd8));
      send_item(make_lookup(point_ohms[42]));
      send_item(make_lookup(point_ohms[42] - 32'd1));
      send_item(make_lookup(32'd0));
      send_item(make_write(6'd0, 16'sd32767, 32'hFFFF_FFFE));
      send_item(make_lookup(32'hFFFF_FFFF));
      send_item(make_lookup(32'hFFFF_FFFE));
      settle();
      write_register(ntc_pkg::CSR_POINTS_IN_USE, 16'd64);
      send_item(make_lookup(32'd0));
      send_item(make_lookup(point_ohms[TABLE_DEPTH-1] + 32'd1));
      settle();
      write_register(ntc_pkg::CSR_TEMP_STEP, 16'd0);
      send_item(make_lookup(point_ohms[1] + 32'd500));
      settle();
      write_register(ntc_pkg::CSR_TEMP_STEP, 16'hFFFF);
      write_register(ntc_pkg::CSR_POINTS_IN_USE, 16'd2);
      send_item(make_lookup(point_ohms[1]));
      send_item(make_lookup(point_ohms[1] - 32'd1));
      settle();
      write_register(ntc_pkg::CSR_TEMP_STEP, ntc_pkg::TEMP_STEP_RESET);
      write_register(ntc_pkg::CSR_POINTS_IN_USE, 16'(ntc_pkg::POINTS_RESET));
   endtask

   task automatic run_random_phase(input logic [15:0] step, input logic [15:0] points_word,
                                   input int unsigned count);
      settle();
      write_register(ntc_pkg::CSR_TEMP_STEP, step);
      write_register(ntc_pkg::CSR_POINTS_IN_USE, points_word);
      load_table();
      repeat (count) send_item(random_item());
   endtask

   task automatic test_random_settings();
      run_random_phase(16'd1, 16'd64, 37);
      run_random_phase(16'hFFFF, 16'd2, 37);
      run_random_phase(16'($urandom_range(200, 1)), 16'($urandom_range(64, 2)), 37);
      run_random_phase(16'd0, 16'd20, 37);
      run_random_phase(16'($urandom_range(16'hFFFF, 1)), 16'hFFFF, 37);
      run_random_phase(16'd5, 16'hFF80, 37);
      run_random_phase(16'($urandom_range(5000, 1)), 16'd1, 37);
      run_random_phase(16'($urandom_range(50, 2)), 16'($urandom_range(64, 2)), 37);
   endtask

   task automatic test_back_to_back();
      req_idle_en = 1'b0;
      rsp_idle_en <= 1'b0;
      repeat (40) send_item(random_item());
      req_idle_en = 1'b1;
      rsp_idle_en <= 1'b1;
   endtask

   task automatic test_backpressure();
      req_idle_en = 1'b0;
      hold_toggle <= ~hold_toggle;
      repeat (16) send_item(make_lookup(pick_measurement()));
      req_idle_en = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         hold_seen = hold_toggle;
      end else begin
         if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= rsp_idle_en && ($urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            $error("unexpected reading: temperature %0d status %0d",
                   rsp_temperature, rsp_status);
            error_count++;
         end else begin
            oldest_reading = expected_readings.pop_front();
            if (rsp_temperature !== oldest_reading.temperature) begin
               $error("temperature: expected %0d, got %0d",
                      oldest_reading.temperature, rsp_temperature);
               error_count++;
            end
            if (rsp_status !== oldest_reading.status) begin
               $error("status: expected %0d, got %0d", oldest_reading.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ntc_table_interpolator_top_test: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_settings();
      test_back_to_back();
      test_backpressure();
      settle();
      if (error_count == 0) begin
         $display("ntc_table_interpolator_top_test: done, clean");
      end else begin
         $display("ntc_table_interpolator_top_test: done, errors");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/ntc_pkg.sv
hdl/ntc_div.sv
hdl/ntc_table_interpolator_top.sv
hdl/ntc_chk.sv
dv/ntc_table_interpolator_top_test.sv
